// ----- design/kss_pkg.sv -----
// ----------------------------------------------------------------------------
// kss_pkg: shared types for the k-th smallest selection block
// Sequencer states, status codes and the float ordering key.
// ----------------------------------------------------------------------------
`default_nettype none
package kss_pkg;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RD_PIVOT,
    ST_WT_PIVOT,
    ST_SCAN_I,
    ST_SCAN_J,
    ST_WR_I,
    ST_WR_J,
    ST_NEXT,
    ST_WT_K,
    ST_OUT
  } kss_state_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_RANK = 2'd1,
    STATUS_DROPPED  = 2'd2
  } kss_status_t;

  // Monotone unsigned key: float order with -0 equal to +0.
  function automatic logic [31:0] order_key(input logic [31:0] bits);
    logic [31:0] b;
    b = (bits == 32'h8000_0000) ? 32'h0 : bits;
    return b[31] ? ~b : (b | 32'h8000_0000);
  endfunction

endpackage
`default_nettype wire

// ----- design/kth_smallest_select_top.sv -----
// ----------------------------------------------------------------------------
// kth_smallest_select_top: k-th smallest of a set of float32 values
// Loads a set, then runs partition selection in place over one memory.
// ----------------------------------------------------------------------------
// Elements are accepted one per cycle and written to a single-port memory of
// MAX_ELEMENTS words. The request marked tlast ends the set and carries the
// rank; the block then runs in-place partition selection, one memory access
// per cycle (a scan step costs one read, a swap two writes). No input is taken
// during selection or while the result waits. Entries past MAX_ELEMENTS are
// dropped and flagged in status. NaN inputs are unsupported.
`default_nettype none
module kth_smallest_select_top
  import kss_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // sample_value[31:0], rank[41:32], zero fill
  input  wire logic        in_tlast,   // last_element
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // selected_value[31:0], status[33:32], zero fill
);
  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int IW = CW + 1; // signed indices

  kss_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic ovf_r, ovf_nxt;
  logic signed [IW-1:0] left_r, left_nxt, right_r, right_nxt;
  logic signed [IW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [31:0] pivot_r, pivot_nxt, vi_r, vi_nxt, vj_r, vj_nxt;
  logic [31:0] res_r, res_nxt;
  logic [1:0]  stat_r, stat_nxt;

  logic          we;
  logic [AW-1:0] addr;
  logic [31:0]   wdata, rdata, rkey;

  kss_store #(.DEPTH(MAX_ELEMENTS), .AW(AW)) u_store (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

  logic in_fire;
  logic [9:0] in_rank;
  assign in_fire = in_tvalid && in_tready;
  assign in_rank = in_tdata[41:32];
  assign rkey = order_key(rdata);
  assign in_tready = (state_r == ST_LOAD);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata = {6'd0, stat_r, res_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
    left_r <= left_nxt; right_r <= right_nxt;
    i_r <= i_nxt; j_r <= j_nxt; k_r <= k_nxt;
    pivot_r <= pivot_nxt; vi_r <= vi_nxt; vj_r <= vj_nxt;
    res_r <= res_nxt; stat_r <= stat_nxt;
  end

  // Scan i: read issued for i last cycle, data present now.
  // Scan j: read issued for j last cycle.
  always_comb begin
    logic [CW:0] cnt_new;
    state_nxt = state_r; count_nxt = count_r; ovf_nxt = ovf_r;
    left_nxt = left_r; right_nxt = right_r; i_nxt = i_r; j_nxt = j_r;
    k_nxt = k_r; pivot_nxt = pivot_r; vi_nxt = vi_r; vj_nxt = vj_r;
    res_nxt = res_r; stat_nxt = stat_r;
    we = 1'b0; addr = '0; wdata = in_tdata[31:0];
    cnt_new = {1'b0, count_r};
    unique case (state_r)
      ST_LOAD: begin
        addr = count_r[AW-1:0];
        if (in_fire) begin
          if (count_r < CW'(MAX_ELEMENTS)) begin
            we = 1'b1;
            cnt_new = {1'b0, count_r} + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          count_nxt = cnt_new[CW-1:0];
          if (in_tlast) begin
            k_nxt = IW'(in_rank);
            left_nxt = '0;
            right_nxt = IW'(cnt_new) - IW'(1);
            count_nxt = '0;
            ovf_nxt = 1'b0;
            if (32'(in_rank) >= 32'(cnt_new)) begin
              res_nxt = '0; stat_nxt = STATUS_BAD_RANK; state_nxt = ST_OUT;
            end else begin
              stat_nxt = (ovf_r || !(count_r < CW'(MAX_ELEMENTS))) ?
                         STATUS_DROPPED : STATUS_OK;
              state_nxt = ST_RD_PIVOT;
            end
          end
        end
      end
      ST_RD_PIVOT: begin
        addr = k_r[AW-1:0];
        if (left_r < right_r) state_nxt = ST_WT_PIVOT;
        else state_nxt = ST_WT_K;
      end
      ST_WT_PIVOT: begin
        pivot_nxt = rkey;
        i_nxt = left_r; j_nxt = right_r;
        addr = left_r[AW-1:0];
        state_nxt = ST_SCAN_I;
      end
      ST_SCAN_I: begin
        if (i_r < right_r && rkey < pivot_r) begin
          i_nxt = i_r + IW'(1);
          addr = i_nxt[AW-1:0];
        end else begin
          vi_nxt = rdata;
          addr = j_r[AW-1:0];
          state_nxt = ST_SCAN_J;
        end
      end
      ST_SCAN_J: begin
        if (j_r > left_r && rkey > pivot_r) begin
          j_nxt = j_r - IW'(1);
          addr = j_nxt[AW-1:0];
        end else begin
          vj_nxt = rdata;
          if (i_r <= j_r) state_nxt = ST_WR_I;
          else state_nxt = ST_NEXT;
        end
      end
      ST_WR_I: begin
        we = 1'b1; addr = i_r[AW-1:0]; wdata = vj_r;
        state_nxt = ST_WR_J;
      end
      ST_WR_J: begin
        we = 1'b1; addr = j_r[AW-1:0]; wdata = vi_r;
        i_nxt = i_r + IW'(1); j_nxt = j_r - IW'(1);
        state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        if (i_r <= j_r) begin
          addr = i_r[AW-1:0];
          state_nxt = ST_SCAN_I;
        end else begin
          if (j_r < k_r) left_nxt = i_r;
          if (i_r > k_r) right_nxt = j_r;
          state_nxt = ST_RD_PIVOT;
        end
      end
      ST_WT_K: begin
        res_nxt = rdata;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_tready) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_LOAD) |-> !in_tready) else $error("input taken while busy");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ELEMENTS)) else $error("count overran store");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed while stalled");
  a_bad_rank_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && stat_r == STATUS_BAD_RANK) |-> (res_r == 32'd0))
    else $error("bad rank result nonzero");
endmodule
`default_nettype wire

// ----- design/kss_store.sv -----
// ----------------------------------------------------------------------------
// kss_store: element memory
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module kss_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [31:0]   wdata,
  output logic      [31:0]   rdata
);
  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: k-th smallest selection block
// Streams float sets with ranks, predicts the selected element and status
// with an in-bench partition select, and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import kss_pkg::*;

  localparam int DEPTH = 1024;

  typedef struct packed {
    logic [31:0] sample;
    logic [9:0]  rank;
    logic        last;
  } sample_req_t;

  typedef struct packed {
    logic [31:0]  value;
    kss_status_t  status;
  } selection_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  kth_smallest_select_top #(.MAX_ELEMENTS(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  sample_req_t pending_reqs[$];
  selection_t  expected_sel[$];
  logic [31:0] set_vals[$];
  bit          set_overflow;
  int          errors;
  int          sets_checked;
  int          reqs_sent;
  bit          no_idle;
  bit          hold_off_req;
  bit          hold_done;
  bit          hold_seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Float order, -0 equal to +0.
  function automatic logic [31:0] float_rank_key(logic [31:0] bits);
    logic [31:0] b;
    b = (bits == 32'h8000_0000) ? 32'h0 : bits;
    if (b[31]) return ~b;
    return b | 32'h8000_0000;
  endfunction

  function automatic logic [31:0] wirth_pick(logic [31:0] arr[$], int k);
    int lo;
    int hi;
    int i;
    int j;
    logic [31:0] piv;
    logic [31:0] t;
    lo = 0;
    hi = arr.size() - 1;
    while (lo < hi) begin
      piv = float_rank_key(arr[k]);
      i = lo;
      j = hi;
      do begin
        while (i < hi && float_rank_key(arr[i]) < piv) i++;
        while (j > lo && float_rank_key(arr[j]) > piv) j--;
        if (i <= j) begin
          t = arr[i]; arr[i] = arr[j]; arr[j] = t;
          i++;
          j--;
        end
      end while (i <= j);
      if (j < k) lo = i;
      if (i > k) hi = j;
    end
    return arr[k];
  endfunction

  task automatic predict_selection(sample_req_t r);
    selection_t s;
    if (set_vals.size() < DEPTH) set_vals.push_back(r.sample);
    else set_overflow = 1'b1;
    if (r.last) begin
      if (r.rank >= set_vals.size()) begin
        s.value = 32'h0;
        s.status = STATUS_BAD_RANK;
      end else begin
        s.value = wirth_pick(set_vals, r.rank);
        s.status = set_overflow ? STATUS_DROPPED : STATUS_OK;
      end
      expected_sel.push_back(s);
      set_vals.delete();
      set_overflow = 1'b0;
    end
  endtask

  function automatic logic [31:0] rand_float(int pool);
    logic [31:0] specials[8];
    specials = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001, 32'h8000_0001};
    case ($urandom_range(0, 3))
      0: return specials[$urandom_range(0, 7)];
      1: return {$urandom_range(0, 1) == 1, 8'h80, 23'($urandom_range(0, pool))};
      default: begin
        logic [31:0] v;
        v = $urandom;
        // keep away from NaN patterns
        if (v[30:23] == 8'hFF) v[22:0] = '0;
        return v;
      end
    endcase
  endfunction

  task automatic queue_set(int n, int k);
    sample_req_t r;
    for (int i = 0; i < n; i++) begin
      r.sample = rand_float(7);
      r.rank = (i == n - 1) ? 10'(k) : 10'($urandom);
      r.last = (i == n - 1);
      pending_reqs.push_back(r);
    end
  endtask

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tlast <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        predict_selection({in_tdata[31:0], in_tdata[41:32], in_tlast});
        reqs_sent++;
      end
      if (pending_reqs.size() > 0 && (no_idle || $urandom_range(0, 5) != 0)) begin
        sample_req_t r;
        r = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {6'h0, r.rank, r.sample};
        in_tlast <= r.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor and receiver stalls
  int hold_cnt;
  int idle_burst;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_cnt = 0;
      idle_burst = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_sel.size() == 0) begin
          $display("%0t unexpected result %h", $time, out_tdata);
          errors++;
        end else begin
          selection_t e;
          e = expected_sel.pop_front();
          if (out_tdata[31:0] !== e.value) begin
            $display("%0t value mismatch: expected %h actual %h", $time, e.value,
                     out_tdata[31:0]);
            errors++;
          end
          if (out_tdata[33:32] !== e.status) begin
            $display("%0t status mismatch: expected %0d actual %0d", $time, e.status,
                     out_tdata[33:32]);
            errors++;
          end
          if (out_tdata[39:34] !== '0) begin
            $display("%0t fill mismatch: expected 0 actual %h", $time, out_tdata[39:34]);
            errors++;
          end
          sets_checked++;
        end
      end
      if (hold_off_req && !hold_done) begin
        hold_seen <= 1'b1;
        hold_cnt++;
        out_tready <= 1'b0;
        if (hold_cnt > 400) hold_done <= 1'b1;
      end else if (idle_burst > 0) begin
        idle_burst--;
        out_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 6) == 0) begin
        idle_burst = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    sample_req_t r;
    int n;
    errors = 0;
    sets_checked = 0;
    reqs_sent = 0;
    no_idle = 0;
    hold_off_req = 0;
    hold_done = 0;
    hold_seen = 0;
    set_overflow = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: single element, rank out of range, signed zeros, extremes.
    r = '{32'h3F80_0000, 10'd0, 1'b1};       pending_reqs.push_back(r);
    r = '{32'hFFFF_FFFF & 32'hFF7F_FFFF, 10'd1, 1'b1}; pending_reqs.push_back(r);
    r = '{32'h8000_0000, 10'h3FF, 1'b0};     pending_reqs.push_back(r);
    r = '{32'h0000_0000, 10'd0, 1'b0};       pending_reqs.push_back(r);
    r = '{32'h7F80_0000, 10'd0, 1'b0};       pending_reqs.push_back(r);
    r = '{32'hFF80_0000, 10'd2, 1'b1};       pending_reqs.push_back(r);
    r = '{32'h7F7F_FFFF, 10'd0, 1'b0};       pending_reqs.push_back(r);
    r = '{32'h0000_0001, 10'd0, 1'b0};       pending_reqs.push_back(r);
    r = '{32'h8000_0001, 10'h3FF, 1'b1};     pending_reqs.push_back(r);
    r = '{32'h4000_0000, 10'd0, 1'b0};       pending_reqs.push_back(r);
    r = '{32'h4000_0000, 10'd0, 1'b0};       pending_reqs.push_back(r);
    r = '{32'hC000_0000, 10'd1, 1'b1};       pending_reqs.push_back(r);
    wait (pending_reqs.size() == 0);

    // Full store plus overflow: drop the tail and flag it.
    queue_set(DEPTH + 3, 517);
    wait (pending_reqs.size() == 0 && expected_sel.size() == 0);

    // Long receiver hold-off while the sender keeps offering.
    hold_off_req = 1;
    for (int s = 0; s < 6; s++) queue_set($urandom_range(2, 8), $urandom_range(0, 7));
    wait (hold_done);
    hold_off_req = 0;
    wait (pending_reqs.size() == 0 && expected_sel.size() == 0);

    // Random sets, mostly small.
    while (reqs_sent < 1400) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
      queue_set(n, ($urandom_range(0, 7) == 0) ? $urandom_range(n, 1023)
                                                : $urandom_range(0, n - 1));
      if (pending_reqs.size() > 40) wait (pending_reqs.size() < 10);
      if (reqs_sent > 1250) no_idle = 1;
    end
    wait (pending_reqs.size() == 0 && !in_tvalid);
    wait (expected_sel.size() == 0);
    repeat (50) @(posedge clk);

    $display("sent %0d samples, checked %0d selections incl. full, overflow", reqs_sent,
             sets_checked);
    $display("and bad-rank sets plus a %0s receiver hold-off", hold_seen ? "long" : "no");
    if (errors == 0 && expected_sel.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
